>>> rtl/core/ccrf_pkg.sv
// Shared types, codes and helpers for the chain code region fill block.
// No dependencies; ccrf_stack and chain_code_region_fill import this package, ccrf_ram does not.
package ccrf_pkg;

  localparam int GRID_SIZE_DEF   = 256;
  localparam int STACK_DEPTH_DEF = 64;

  // item modes
  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_TRACE = 3'd2;
  localparam logic [2:0] MODE_FILL  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // chain code directions, counterclockwise from right, y grows upward
  localparam logic [2:0] DIR_R  = 3'd0;
  localparam logic [2:0] DIR_UR = 3'd1;
  localparam logic [2:0] DIR_U  = 3'd2;
  localparam logic [2:0] DIR_UL = 3'd3;
  localparam logic [2:0] DIR_L  = 3'd4;
  localparam logic [2:0] DIR_DL = 3'd5;
  localparam logic [2:0] DIR_D  = 3'd6;
  localparam logic [2:0] DIR_DR = 3'd7;

  // stored cell labels, equal to the reported codes
  localparam logic [1:0] LBL_OUT  = 2'd0;
  localparam logic [1:0] LBL_IN   = 2'd1;
  localparam logic [1:0] LBL_EDGE = 2'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [2:0] direction;
  } ccrf_in_t;

  typedef struct packed {
    logic [1:0] cell_label;
    logic       stack_overflow;
    logic       position_error;
  } ccrf_out_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  // inside turns outside, edge stays, anything else turns inside
  function automatic logic [1:0] lbl_toggle(input logic [1:0] lbl);
    logic [1:0] res;
    res = LBL_IN;
    if (lbl == LBL_IN) begin
      res = LBL_OUT;
    end else if (lbl == LBL_EDGE) begin
      res = LBL_EDGE;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/ccrf_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module ccrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ccrf_stack.sv
// Column stack: fill count in flops, entries in a ccrf_ram instance.
// Depends on ccrf_pkg and ccrf_ram. Pop data is registered and appears in the cycle after the pop.
module ccrf_stack #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccrf_pkg::stk_cmd_t  cmd_i,
  input  logic [WIDTH-1:0]    data_i,
  output logic [WIDTH-1:0]    data_o,
  output ccrf_pkg::stk_stat_t stat_o
);
  import ccrf_pkg::*;

  localparam int SCW = $clog2(DEPTH + 1);
  localparam int SAW = $clog2(DEPTH);

  logic [SCW-1:0] count_q, count_d;
  logic [SCW-1:0] cnt_m1;

  assign cnt_m1       = count_q - SCW'(1);
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == SCW'(DEPTH));

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + SCW'(1);
    end else if (cmd_i.pop) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  ccrf_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(count_q[SAW-1:0]),
    .wdata_i(data_i),
    .re_i   (cmd_i.pop),
    .raddr_i(cnt_m1[SAW-1:0]),
    .rdata_o(data_o)
  );

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.pop))
    else $error("stack push and pop in one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SCW'(DEPTH))
    else $error("stack count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("push into a full stack");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stat_o.empty)
    else $error("pop from an empty stack");

endmodule

>>> rtl/core/chain_code_region_fill.sv
// Chain code region fill: label grid in one RAM (one cell per word), two column stacks.
// Fill with pop toggles the row cells strictly between the popped x and the old x, one cell
// per cycle through the RAM port; clear writes every cell back to outside. One item at a time;
// busy stays high until done. Reset runs a clearing pass of every label RAM cell with busy high.
// Each result is a one-cycle strobe on res_valid_o; the receiver cannot stall.
module chain_code_region_fill #(
  parameter int GRID_SIZE   = ccrf_pkg::GRID_SIZE_DEF,
  parameter int STACK_DEPTH = ccrf_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ccrf_pkg::ccrf_in_t  item_i,
  output logic                res_valid_o,
  output ccrf_pkg::ccrf_out_t result_o
);
  import ccrf_pkg::*;

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int EW    = ((CW > 8) ? CW : 8) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_POP   = 3'd3;
  localparam logic [2:0] ST_SPAN  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
    return AW'(y) * AW'(GRID_SIZE) + AW'(x);
  endfunction

  logic [2:0]    state_q, state_d;
  ccrf_in_t      item_q, item_d;
  ccrf_out_t     res_q, res_d;
  logic          rsp_pend_q, rsp_pend_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CW-1:0] ox_q, ox_d, row_q, row_d, hi_q, hi_d;
  logic [CW:0]   sx_q, sx_d;
  logic          pop_left_q, pop_left_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic [AW-1:0] clr_q, clr_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_wdata, ram_rdata;

  stk_cmd_t      lstk_cmd, rstk_cmd;
  stk_stat_t     lstk_stat, rstk_stat;
  logic [CW-1:0] lstk_data, rstk_data;

  logic          dx_pos, dx_neg, dy_pos, dy_neg;
  logic          move_ok;
  logic [CW-1:0] nx, ny;
  logic          pos_ok;
  logic [CW-1:0] pop_val, span_lo, span_hi;
  logic          sx_lt;

  // move decode
  always_comb begin
    dx_pos = 1'b0;
    dx_neg = 1'b0;
    dy_pos = 1'b0;
    dy_neg = 1'b0;
    case (item_q.direction)
      DIR_R:  dx_pos = 1'b1;
      DIR_UR: begin dx_pos = 1'b1; dy_pos = 1'b1; end
      DIR_U:  dy_pos = 1'b1;
      DIR_UL: begin dx_neg = 1'b1; dy_pos = 1'b1; end
      DIR_L:  dx_neg = 1'b1;
      DIR_DL: begin dx_neg = 1'b1; dy_neg = 1'b1; end
      DIR_D:  dy_neg = 1'b1;
      DIR_DR: begin dx_pos = 1'b1; dy_neg = 1'b1; end
      default: dx_pos = 1'b0;
    endcase
  end

  assign move_ok = !(dx_pos && cur_x_q == CW'(GRID_SIZE - 1)) &&
                   !(dx_neg && cur_x_q == '0) &&
                   !(dy_pos && cur_y_q == CW'(GRID_SIZE - 1)) &&
                   !(dy_neg && cur_y_q == '0);
  assign nx = dx_pos ? cur_x_q + CW'(1) : (dx_neg ? cur_x_q - CW'(1) : cur_x_q);
  assign ny = dy_pos ? cur_y_q + CW'(1) : (dy_neg ? cur_y_q - CW'(1) : cur_y_q);

  assign pos_ok = (EW'(item_q.pos_x) < EW'(GRID_SIZE)) &&
                  (EW'(item_q.pos_y) < EW'(GRID_SIZE));

  assign pop_val = pop_left_q ? lstk_data : rstk_data;
  assign span_lo = (pop_val < ox_q) ? pop_val : ox_q;
  assign span_hi = (pop_val < ox_q) ? ox_q : pop_val;
  assign sx_lt   = sx_q < {1'b0, hi_q};

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    rsp_pend_d  = rsp_pend_q;
    out_valid_d = 1'b0;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    ox_d        = ox_q;
    row_d       = row_q;
    hi_d        = hi_q;
    sx_d        = sx_q;
    pop_left_d  = pop_left_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    clr_d       = clr_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = LBL_OUT;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    lstk_cmd    = '0;
    rstk_cmd    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d     = item_i;
          res_d      = '0;
          rsp_pend_d = 1'b1;
          state_d    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = rsp_pend_q;
        rsp_pend_d  = 1'b0;
        case (item_q.mode)
          MODE_CLEAR: begin
            clr_d       = '0;
            state_d     = ST_CLEAR;
            out_valid_d = 1'b0;
            rsp_pend_d  = rsp_pend_q;
          end
          MODE_START: begin
            if (pos_ok) begin
              cur_x_d        = CW'(item_q.pos_x);
              cur_y_d        = CW'(item_q.pos_y);
              lstk_cmd.clear = 1'b1;
              rstk_cmd.clear = 1'b1;
            end else begin
              res_d.position_error = 1'b1;
            end
          end
          MODE_TRACE, MODE_FILL: begin
            if (!move_ok) begin
              res_d.position_error = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(cur_x_q, cur_y_q);
              ram_wdata = LBL_EDGE;
              cur_x_d   = nx;
              cur_y_d   = ny;
              ox_d      = cur_x_q;
              // up moves fill the current row, down moves the row below
              row_d     = dy_neg ? cur_y_q - CW'(1) : cur_y_q;
              if (item_q.mode == MODE_FILL && dy_pos) begin
                if (!rstk_stat.empty) begin
                  rstk_cmd.pop = 1'b1;
                  pop_left_d   = 1'b0;
                  state_d      = ST_POP;
                  out_valid_d  = 1'b0;
                  rsp_pend_d   = rsp_pend_q;
                end else if (!lstk_stat.full) begin
                  lstk_cmd.push = 1'b1;
                end else begin
                  res_d.stack_overflow = 1'b1;
                end
              end else if (item_q.mode == MODE_FILL && dy_neg) begin
                if (!lstk_stat.empty) begin
                  lstk_cmd.pop = 1'b1;
                  pop_left_d   = 1'b1;
                  state_d      = ST_POP;
                  out_valid_d  = 1'b0;
                  rsp_pend_d   = rsp_pend_q;
                end else if (!rstk_stat.full) begin
                  rstk_cmd.push = 1'b1;
                end else begin
                  res_d.stack_overflow = 1'b1;
                end
              end
            end
          end
          MODE_READ: begin
            if (pos_ok) begin
              ram_re      = 1'b1;
              ram_raddr   = cell_addr(CW'(item_q.pos_x), CW'(item_q.pos_y));
              state_d     = ST_READ;
              out_valid_d = 1'b0;
              rsp_pend_d  = rsp_pend_q;
            end
          end
          default: res_d = '0;
        endcase
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = LBL_OUT;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d     = ST_IDLE;
          out_valid_d = rsp_pend_q;
          rsp_pend_d  = 1'b0;
        end
      end

      ST_POP: begin
        sx_d    = {1'b0, span_lo} + (CW + 1)'(1);
        hi_d    = span_hi;
        state_d = ST_SPAN;
      end

      ST_SPAN: begin
        // read one cell per cycle, write it back toggled in the next cycle
        if (sx_lt) begin
          ram_re      = 1'b1;
          ram_raddr   = cell_addr(sx_q[CW-1:0], row_q);
          pend_d      = 1'b1;
          pend_addr_d = ram_raddr;
          sx_d        = sx_q + (CW + 1)'(1);
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = lbl_toggle(ram_rdata);
        end
        // finish together with the last write back
        if (!sx_lt) begin
          state_d     = ST_IDLE;
          out_valid_d = rsp_pend_q;
          rsp_pend_d  = 1'b0;
        end
      end

      ST_READ: begin
        res_d.cell_label = ram_rdata;
        state_d          = ST_IDLE;
        out_valid_d      = rsp_pend_q;
        rsp_pend_d       = 1'b0;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_pend_q  <= rsp_pend_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    res_q       <= res_d;
    ox_q        <= ox_d;
    row_q       <= row_d;
    hi_q        <= hi_d;
    sx_q        <= sx_d;
    pop_left_q  <= pop_left_d;
    pend_addr_q <= pend_addr_d;
  end

  ccrf_ram #(
    .WIDTH(2),
    .DEPTH(CELLS)
  ) u_label_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ccrf_stack #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(CW)
  ) u_left_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (lstk_cmd),
    .data_i(cur_x_q),
    .data_o(lstk_data),
    .stat_o(lstk_stat)
  );

  ccrf_stack #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(CW)
  ) u_right_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (rstk_cmd),
    .data_i(cur_x_q),
    .data_o(rstk_data),
    .stat_o(rstk_stat)
  );

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign result_o    = res_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while still working");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(rsp_pend_q))
    else $error("result strobe without an accepted item");

  a_rmw_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("label read and write hit the same cell");

endmodule
